// ===== rtl/core/chained_hash_table_grow_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the chained hash table
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_GROW_MACROS_SVH
`define CHAINED_HASH_TABLE_GROW_MACROS_SVH

// same-cycle implication
`define CHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define CHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/cht_pkg.sv =====
// ----------------------------------------------------------------------------
// cht_pkg
// Operation, status and sequencer codes of the chained hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef logic [3:0] state_t;

	localparam state_t ST_CLR   = 4'd0;
	localparam state_t ST_IDLE  = 4'd1;
	localparam state_t ST_LRF   = 4'd2;
	localparam state_t ST_LWF   = 4'd3;
	localparam state_t ST_LSLOT = 4'd4;
	localparam state_t ST_DONE  = 4'd5;
	localparam state_t ST_SRF   = 4'd6;
	localparam state_t ST_SWF   = 4'd7;
	localparam state_t ST_SSLOT = 4'd8;
	localparam state_t ST_SWF0  = 4'd9;
	localparam state_t ST_SWF1  = 4'd10;

endpackage

// ===== rtl/core/chained_hash_table_grow.sv =====
// ----------------------------------------------------------------------------
// chained_hash_table_grow
// Chained hash table over 64-bit hashes with power-of-two bucket growth.
// ----------------------------------------------------------------------------
// An item reads its bucket's fill count and then scans one slot at a time in
// its bucket (at most BUCKET_WAYS), bounded by the single read port of the
// slot memory; one item is in flight at a time and a finished result waits
// in the output register. After reset the block clears the fill counts of
// the INITIAL_BUCKETS initial buckets before it takes an item. An insert that
// trips the load rule first splits the table: per old bucket it reads the
// fill count, moves each entry to the old or the new upper bucket and writes
// both fill counts. INITIAL_BUCKETS and MAX_BUCKETS must be powers of two.
// ----------------------------------------------------------------------------
module chained_hash_table_grow
	import cht_pkg::*;
#(
	parameter int MAX_BUCKETS     = 1024,
	parameter int BUCKET_WAYS     = 4,
	parameter int INITIAL_BUCKETS = 4,
	parameter int GROW_DIVISOR    = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [63:0] key,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic        status,
	output logic [12:0] stored_entries
);

	localparam int IW    = $clog2(MAX_BUCKETS);
	localparam int BW    = IW + 1;
	localparam int WW    = $clog2(BUCKET_WAYS + 1);
	localparam int SLOTS = MAX_BUCKETS * BUCKET_WAYS;
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int EW    = $clog2(SLOTS + 1);
	localparam int LVLS  = $clog2(MAX_BUCKETS / INITIAL_BUCKETS);

	function automatic int lim_at(input int i);
		int n;
		n = INITIAL_BUCKETS << i;
		return n - n / GROW_DIVISOR;
	endfunction

	function automatic logic [AW-1:0] slot_at(input logic [IW-1:0] b, input logic [WW-1:0] w);
		return AW'(b) * AW'(BUCKET_WAYS) + AW'(w);
	endfunction

	logic [WW-1:0] fill_mem [MAX_BUCKETS];
	logic [95:0]   slot_mem [SLOTS];

	state_t        state_q;
	logic          op_q;
	logic [63:0]   key_q;
	logic [31:0]   val_q;
	logic [BW-1:0] bc_q;
	logic [EW-1:0] cnt_q;
	logic [IW-1:0] b_q;
	logic [WW-1:0] w_q;
	logic [WW-1:0] fill_q;
	logic [WW-1:0] keep_q;
	logic [WW-1:0] moved_q;
	logic          hit_q;
	logic          out_valid_q;
	logic          out_hit_q;
	logic          out_status_q;
	logic [EW-1:0] out_cnt_q;

	logic [IW-1:0] fill_ra;
	logic          fill_we;
	logic [IW-1:0] fill_wa;
	logic [WW-1:0] fill_wd;
	logic [WW-1:0] fill_rd;
	logic [AW-1:0] slot_ra;
	logic          slot_we;
	logic [AW-1:0] slot_wa;
	logic [95:0]   slot_wd;
	logic [95:0]   slot_rd;

	logic [IW-1:0] idx;
	logic [IW-1:0] hi_b;
	logic [EW-1:0] limit;
	logic [WW-1:0] w_nx;
	logic          more;
	logic          match;
	logic          moves;
	logic          out_free;
	logic          grow;

	always_ff @(posedge clk) begin
		if (fill_we)
			fill_mem[fill_wa] <= fill_wd;
		fill_rd <= fill_mem[fill_ra];
	end

	always_ff @(posedge clk) begin
		if (slot_we)
			slot_mem[slot_wa] <= slot_wd;
		slot_rd <= slot_mem[slot_ra];
	end

	always_comb begin
		limit = '0;
		for (int i = 0; i <= LVLS; i++) begin
			if (bc_q == BW'(INITIAL_BUCKETS << i))
				limit = EW'(lim_at(i));
		end
	end

	assign idx      = key_q[IW-1:0] & IW'(bc_q - BW'(1));
	assign hi_b     = b_q + IW'(bc_q);
	assign w_nx     = w_q + WW'(1);
	assign more     = w_nx < fill_q;
	assign match    = slot_rd[95:32] == key_q;
	assign moves    = |(slot_rd[32+IW-1:32] & IW'(bc_q));
	assign out_free = !out_valid_q || out_ready;
	assign grow     = (opcode == OP_INSERT) && (cnt_q >= limit)
		&& (bc_q <= BW'(MAX_BUCKETS / 2));

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		fill_ra = idx;
		fill_we = 1'b0;
		fill_wa = idx;
		fill_wd = '0;
		slot_ra = slot_at(idx, '0);
		slot_we = 1'b0;
		slot_wa = slot_at(idx, w_q);
		slot_wd = {key_q, val_q};
		unique case (state_q)
			ST_CLR: begin
				fill_we = 1'b1;
				fill_wa = b_q;
			end
			ST_LSLOT: slot_ra = slot_at(idx, w_nx);
			ST_DONE: begin
				if (out_free && op_q == OP_INSERT) begin
					if (hit_q) begin
						slot_we = 1'b1;
					end else if (fill_q < WW'(BUCKET_WAYS)) begin
						slot_we = 1'b1;
						slot_wa = slot_at(idx, fill_q);
						fill_we = 1'b1;
						fill_wd = fill_q + WW'(1);
					end
				end
			end
			ST_SRF: fill_ra = b_q;
			ST_SWF: slot_ra = slot_at(b_q, '0);
			ST_SSLOT: begin
				slot_ra = slot_at(b_q, w_nx);
				slot_we = 1'b1;
				slot_wd = slot_rd;
				slot_wa = moves ? slot_at(hi_b, moved_q) : slot_at(b_q, keep_q);
			end
			ST_SWF0: begin
				fill_we = 1'b1;
				fill_wa = b_q;
				fill_wd = keep_q;
			end
			ST_SWF1: begin
				fill_we = 1'b1;
				fill_wa = hi_b;
				fill_wd = moved_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			bc_q        <= BW'(INITIAL_BUCKETS);
			cnt_q       <= '0;
			b_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					if (b_q == IW'(INITIAL_BUCKETS - 1)) begin
						b_q     <= '0;
						state_q <= ST_IDLE;
					end else begin
						b_q <= b_q + IW'(1);
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						b_q     <= '0;
						state_q <= grow ? ST_SRF : ST_LRF;
					end
				end
				ST_LRF: state_q <= ST_LWF;
				ST_LWF: state_q <= (fill_rd != '0) ? ST_LSLOT : ST_DONE;
				ST_LSLOT: begin
					if (match || !more)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						if (op_q == OP_INSERT && !hit_q && fill_q < WW'(BUCKET_WAYS))
							cnt_q <= cnt_q + EW'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_SRF: state_q <= ST_SWF;
				ST_SWF: state_q <= (fill_rd != '0) ? ST_SSLOT : ST_SWF0;
				ST_SSLOT: begin
					if (!more)
						state_q <= ST_SWF0;
				end
				ST_SWF0: state_q <= ST_SWF1;
				ST_SWF1: begin
					if (b_q == IW'(bc_q - BW'(1))) begin
						bc_q    <= bc_q << 1;
						b_q     <= '0;
						state_q <= ST_LRF;
					end else begin
						b_q     <= b_q + IW'(1);
						state_q <= ST_SRF;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				op_q  <= opcode;
				key_q <= key;
				val_q <= value;
				hit_q <= 1'b0;
			end
			ST_LWF: begin
				fill_q <= fill_rd;
				w_q    <= '0;
			end
			ST_LSLOT: begin
				if (match)
					hit_q <= 1'b1;
				else
					w_q <= w_nx;
			end
			ST_DONE: begin
				if (out_free) begin
					out_hit_q    <= hit_q;
					out_status_q <= (op_q == OP_INSERT && !hit_q
						&& fill_q >= WW'(BUCKET_WAYS)) ? STATUS_FULL : STATUS_OK;
					out_cnt_q    <= (op_q == OP_INSERT && !hit_q
						&& fill_q < WW'(BUCKET_WAYS)) ? cnt_q + EW'(1) : cnt_q;
				end
			end
			ST_SWF: begin
				fill_q  <= fill_rd;
				w_q     <= '0;
				keep_q  <= '0;
				moved_q <= '0;
			end
			ST_SSLOT: begin
				w_q <= w_nx;
				if (moves)
					moved_q <= moved_q + WW'(1);
				else
					keep_q <= keep_q + WW'(1);
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign hit            = out_hit_q;
	assign status         = out_status_q;
	assign stored_entries = 13'(out_cnt_q);

endmodule

// ===== rtl/core/cht_checker.sv =====
// ----------------------------------------------------------------------------
// cht_checker
// Port-level checks of the chained hash table, bound to the top level.
// ----------------------------------------------------------------------------
`include "chained_hash_table_grow_macros.svh"

module cht_checker
	import cht_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        hit,
	input logic        status,
	input logic [12:0] stored_entries
);

	`CHT_ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready)
	`CHT_ASSERT_NOW(a_full_no_hit, clk, arst_n, out_valid && status == STATUS_FULL, !hit)
	`CHT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`CHT_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(stored_entries) && $stable(hit) && $stable(status))

endmodule

bind chained_hash_table_grow cht_checker u_cht_checker (.*);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for chained_hash_table_grow. Items are predicted from a local
// model of the table (buckets, fills, key/value slots, growth by splitting)
// and every result is checked in order against the expected queue.
// Directed items cover key and value extremes, updates, lookups and a full
// bucket. Random items mix new keys, reused keys and lookups under varying
// idle rates on both sides. A fill pass grows the table to its bucket limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import cht_pkg::*;

	localparam int NBUCKETS_MAX = 1024;
	localparam int NWAYS        = 4;
	localparam int NBUCKETS_INI = 4;
	localparam int GROW_DIV     = 4;
	localparam int CYCLE_LIMIT  = 3000000;

	typedef struct packed {
		logic        hit;
		logic        status;
		logic [12:0] entries;
	} table_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        opcode;
	logic [63:0] key;
	logic [31:0] value;
	logic        out_valid;
	logic        out_ready;
	logic        hit;
	logic        status;
	logic [12:0] stored_entries;

	// table model
	int unsigned   bucket_cnt;
	int unsigned   entry_cnt;
	int unsigned   fill_of[NBUCKETS_MAX];
	logic [63:0]   slot_key[NBUCKETS_MAX * NWAYS];
	logic [31:0]   slot_val[NBUCKETS_MAX * NWAYS];

	table_result_t expected_q[$];
	logic [63:0]   known_keys[$];
	int            errors;
	int            cycles;
	int            send_idle_pct;
	int            recv_idle_pct;
	int            hold_cycles;

	chained_hash_table_grow u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.key(key),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit(hit),
		.status(status),
		.stored_entries(stored_entries)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic split_buckets();
		int unsigned nc;
		int unsigned keep;
		int unsigned moved;
		int unsigned hb;
		logic [63:0] k;
		logic [31:0] v;
		nc = bucket_cnt * 2;
		for (int unsigned b = 0; b < bucket_cnt; b++) begin
			keep = 0;
			moved = 0;
			hb = b + bucket_cnt;
			for (int unsigned w = 0; w < fill_of[b]; w++) begin
				k = slot_key[b * NWAYS + w];
				v = slot_val[b * NWAYS + w];
				if (k % nc == b) begin
					slot_key[b * NWAYS + keep] = k;
					slot_val[b * NWAYS + keep] = v;
					keep++;
				end else begin
					slot_key[hb * NWAYS + moved] = k;
					slot_val[hb * NWAYS + moved] = v;
					moved++;
				end
			end
			fill_of[b] = keep;
			fill_of[hb] = moved;
		end
		bucket_cnt = nc;
	endtask

	task automatic apply_item(input logic op, input logic [63:0] k, input logic [31:0] v);
		table_result_t r;
		int unsigned idx;
		int unsigned w;
		r = '0;
		if (op == OP_INSERT && entry_cnt >= bucket_cnt - bucket_cnt / GROW_DIV
				&& bucket_cnt * 2 <= NBUCKETS_MAX)
			split_buckets();
		idx = 32'(k % bucket_cnt);
		for (w = 0; w < fill_of[idx]; w++) begin
			if (slot_key[idx * NWAYS + w] == k) begin
				r.hit = 1'b1;
				break;
			end
		end
		r.status = STATUS_OK;
		if (op == OP_INSERT) begin
			if (r.hit) begin
				slot_val[idx * NWAYS + w] = v;
			end else if (fill_of[idx] >= NWAYS) begin
				r.status = STATUS_FULL;
			end else begin
				slot_key[idx * NWAYS + fill_of[idx]] = k;
				slot_val[idx * NWAYS + fill_of[idx]] = v;
				fill_of[idx]++;
				entry_cnt++;
				known_keys.push_back(k);
			end
		end
		r.entries = entry_cnt[12:0];
		expected_q.push_back(r);
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			apply_item(opcode, key, value);
	end

	always @(posedge clk) begin
		table_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected: hit=%0b status=%0b entries=%0d",
					$time, hit, status, stored_entries);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (hit !== e.hit) begin
					$display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
					errors++;
				end
				if (status !== e.status) begin
					$display("%0t: status expected %0b actual %0b", $time, e.status, status);
					errors++;
				end
				if (stored_entries !== e.entries) begin
					$display("%0t: stored_entries expected %0d actual %0d",
						$time, e.entries, stored_entries);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_item(input logic op, input logic [63:0] k, input logic [31:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		opcode = op;
		key = k;
		value = v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	function automatic logic [63:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	task automatic test_directed();
		send_item(OP_LOOKUP, 64'd0, 32'd0);
		send_item(OP_INSERT, 64'd0, 32'd0);
		send_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
		send_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h5A5A_A5A5);
		send_item(OP_LOOKUP, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF);
		// same low bits at every table size: fill bucket zero past its ways
		for (int i = 1; i <= 5; i++)
			send_item(OP_INSERT, 64'(i) << 20, $urandom);
		send_item(OP_INSERT, 64'd1 << 20, 32'h1234_5678);
		send_item(OP_LOOKUP, 64'd5 << 20, 32'd0);
		send_item(OP_LOOKUP, 64'd4 << 20, 32'd0);
		send_item(OP_INSERT, 64'd5 << 20, 32'd0);
	endtask

	task automatic test_random(input int n);
		logic        op;
		logic [63:0] k;
		int          pick;
		for (int i = 0; i < n; i++) begin
			op = ($urandom_range(99) < 40) ? OP_LOOKUP : OP_INSERT;
			pick = $urandom_range(99);
			if (pick < 40 && known_keys.size() > 0)
				k = known_keys[$urandom_range(known_keys.size() - 1)];
			else if (pick < 60)
				k = 64'($urandom_range(63)) << $urandom_range(12);
			else
				k = rand_key();
			send_item(op, k, $urandom);
		end
	endtask

	task automatic test_backpressure();
		hold_cycles = 300;
		test_random(20);
		wait (expected_q.size() == 0);
		@(negedge clk);
		test_random(10);
	endtask

	task automatic test_grow_to_limit();
		logic [63:0] base;
		int unsigned i;
		base = rand_key() & ~64'hFFFF;
		i = 0;
		while (bucket_cnt < NBUCKETS_MAX
				|| entry_cnt < NBUCKETS_MAX - NBUCKETS_MAX / GROW_DIV + 20) begin
			send_item(OP_INSERT, base + i, $urandom);
			i++;
			@(negedge clk);
		end
		test_random(40);
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		hold_cycles = 0;
		bucket_cnt = NBUCKETS_INI;
		entry_cnt = 0;
		foreach (fill_of[b])
			fill_of[b] = 0;
		in_valid = 1'b0;
		opcode = OP_INSERT;
		key = '0;
		value = '0;
		out_ready = 1'b0;
		send_idle_pct = 14;
		recv_idle_pct = 70;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_backpressure();
		test_random(170);
		send_idle_pct = 70;
		recv_idle_pct = 14;
		test_random(200);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(200);
		test_grow_to_limit();

		wait (expected_q.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== chained_hash_table_grow.f =====
+incdir+rtl/core
rtl/core/cht_pkg.sv
rtl/core/chained_hash_table_grow.sv
rtl/core/cht_checker.sv
test/tb.sv
